// File: rtl/core/cas_pkg.sv
// Shared types, constants and helpers for the clock, alarm and stopwatch controller.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package cas_pkg;

  localparam int unsigned KEY_COUNT = 4;

  // Key positions within the key level vector
  localparam int unsigned KEY_MODE    = 0;
  localparam int unsigned KEY_HOUR    = 1;
  localparam int unsigned KEY_MINUTE  = 2;
  localparam int unsigned KEY_SILENCE = 3;

  localparam int unsigned TPS_W = 10;
  localparam int unsigned SEC_W = 17;

  localparam logic [TPS_W-1:0] TPS_RESET        = TPS_W'(100);
  localparam logic [SEC_W-1:0] SECONDS_PER_DAY  = SEC_W'(86400);
  localparam logic [SEC_W-1:0] SECONDS_PER_HOUR = SEC_W'(3600);
  localparam logic [SEC_W-1:0] SECONDS_PER_MIN  = SEC_W'(60);
  localparam logic [4:0]       HOURS_PER_DAY    = 5'd24;
  localparam logic [5:0]       MINUTES_PER_HOUR = 6'd60;

  // Mode codes as they appear on the result
  localparam logic [1:0] MODE_CODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_CODE_STOPWATCH = 2'd1;
  localparam logic [1:0] MODE_CODE_ALARM_SET = 2'd2;

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'b001,
    MODE_STOPWATCH = 3'b010,
    MODE_ALARM_SET = 3'b100
  } cas_mode_e;

  typedef struct packed {
    logic       key_mode_level;
    logic       key_hour_level;
    logic       key_minute_level;
    logic       key_silence_level;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
    logic       tick_10ms;
  } cas_in_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SEC_W-1:0] alarm_seconds;
    logic [SEC_W-1:0] stopwatch_seconds;
    logic             stopwatch_paused;
    logic             buzzer_on;
  } cas_out_t;

  function automatic logic [1:0] mode_code(input cas_mode_e m);
    logic [1:0] code;
    unique case (m)
      MODE_NORMAL:    code = MODE_CODE_NORMAL;
      MODE_STOPWATCH: code = MODE_CODE_STOPWATCH;
      MODE_ALARM_SET: code = MODE_CODE_ALARM_SET;
      default:        code = MODE_CODE_NORMAL;
    endcase
    return code;
  endfunction

  // Binary 0..59 to packed BCD; tens taken by a reciprocal multiply (103/1024)
  function automatic logic [7:0] to_bcd2(input logic [5:0] v);
    logic [12:0] prod;
    logic [3:0]  tens;
    logic [5:0]  units;
    prod  = 13'(v) * 13'd103;
    tens  = {1'b0, prod[12:10]};
    units = v - 6'(tens) * 6'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cas_in_stage.sv
// Input register of the controller: captures one scan transaction per cycle unless stalled.
// Depends on cas_pkg for the scan payload type.
`default_nettype none

module cas_in_stage import cas_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire cas_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output cas_in_t      out_data_o
);

  logic    valid_q;
  cas_in_t data_q;

  // Hold only while a captured scan cannot move on
  assign in_stall_o = valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/cas_engine.sv
// Controller state and result register: key release detection, mode stepping,
// prescaler, stopwatch, alarm setting and buzzer. Depends on cas_pkg.
`default_nettype none

module cas_engine import cas_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TPS_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire cas_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output cas_out_t              out_data_o
);

  logic [TPS_W-1:0]     tps_q;
  cas_mode_e            mode_q, mode_d;
  logic [KEY_COUNT-1:0] held_q, held_d;
  logic [4:0]           al_hour_q, al_hour_d;
  logic [5:0]           al_min_q, al_min_d;
  logic [SEC_W-1:0]     sw_q, sw_d;
  logic                 paused_q, paused_d;
  logic                 buzzer_q, buzzer_d;
  logic [TPS_W-1:0]     tick_cnt_q, tick_cnt_d;
  logic                 pending_q, pending_d;
  logic                 out_valid_q;
  cas_out_t             out_q, out_d;

  logic                 fire;
  logic [KEY_COUNT-1:0] level;
  logic [KEY_COUNT-1:0] released;
  logic [TPS_W-1:0]     tick_inc;
  logic [6:0]           min_sum;
  logic                 min_carry;
  logic [5:0]           hour_sum;
  logic [SEC_W-1:0]     sw_inc;
  logic                 alarm_match;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;

  assign level[KEY_MODE]    = in_data_i.key_mode_level;
  assign level[KEY_HOUR]    = in_data_i.key_hour_level;
  assign level[KEY_MINUTE]  = in_data_i.key_minute_level;
  assign level[KEY_SILENCE] = in_data_i.key_silence_level;

  // A key is released when it was held and reads high again
  assign released = held_q & level;

  assign tick_inc = tick_cnt_q + TPS_W'(1);
  assign sw_inc   = sw_q + SEC_W'(1);

  // Alarm seconds are always zero, so the second field must read 0x00
  assign alarm_match = ({2'b00, in_data_i.hour_bcd} == to_bcd2({1'b0, al_hour_q}))
                     && ({1'b0, in_data_i.minute_bcd} == to_bcd2(al_min_q))
                     && (in_data_i.second_bcd == 7'h00);

  always_comb begin
    mode_d     = mode_q;
    held_d     = ~level;
    al_hour_d  = al_hour_q;
    al_min_d   = al_min_q;
    sw_d       = sw_q;
    paused_d   = paused_q;
    buzzer_d   = buzzer_q;
    tick_cnt_d = tick_cnt_q;
    pending_d  = pending_q;
    min_sum    = {1'b0, al_min_q};
    min_carry  = 1'b0;
    hour_sum   = {1'b0, al_hour_q};

    if (in_data_i.tick_10ms) begin
      if (tick_inc >= tps_q) begin
        tick_cnt_d = '0;
        pending_d  = 1'b1;
      end else begin
        tick_cnt_d = tick_inc;
      end
    end

    if (released[KEY_MODE]) begin
      unique case (mode_q)
        MODE_NORMAL:    mode_d = MODE_STOPWATCH;
        MODE_STOPWATCH: mode_d = MODE_ALARM_SET;
        MODE_ALARM_SET: mode_d = MODE_NORMAL;
        default:        mode_d = MODE_NORMAL;
      endcase
    end

    if (released[KEY_SILENCE]) begin
      buzzer_d = 1'b0;
    end

    unique case (mode_d)
      MODE_NORMAL: begin
        if ((al_hour_q != '0 || al_min_q != '0) && alarm_match) begin
          buzzer_d = 1'b1;
        end
      end
      MODE_STOPWATCH: begin
        paused_d = paused_q ^ released[KEY_MINUTE];
        if (!paused_d && pending_d) begin
          pending_d = 1'b0;
          sw_d      = (sw_inc >= SECONDS_PER_DAY) ? '0 : sw_inc;
        end
        if (released[KEY_HOUR] && paused_d) begin
          sw_d = '0;
        end
      end
      MODE_ALARM_SET: begin
        // Minute carries into the hour; a full day clears the alarm
        min_sum   = {1'b0, al_min_q} + 7'(released[KEY_MINUTE]);
        min_carry = (min_sum == {1'b0, MINUTES_PER_HOUR});
        hour_sum  = {1'b0, al_hour_q} + 6'(released[KEY_HOUR]) + 6'(min_carry);
        if (hour_sum >= {1'b0, HOURS_PER_DAY}) begin
          al_hour_d = '0;
          al_min_d  = '0;
        end else begin
          al_hour_d = hour_sum[4:0];
          al_min_d  = min_carry ? '0 : min_sum[5:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.mode              = mode_code(mode_d);
    out_d.alarm_seconds     = SEC_W'(al_hour_d) * SECONDS_PER_HOUR
                            + SEC_W'(al_min_d) * SECONDS_PER_MIN;
    out_d.stopwatch_seconds = sw_d;
    out_d.stopwatch_paused  = paused_d;
    out_d.buzzer_on         = buzzer_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NORMAL;
      held_q     <= '0;
      al_hour_q  <= '0;
      al_min_q   <= '0;
      sw_q       <= '0;
      paused_q   <= 1'b1;
      buzzer_q   <= 1'b0;
      tick_cnt_q <= '0;
      pending_q  <= 1'b0;
    end else if (fire) begin
      mode_q     <= mode_d;
      held_q     <= held_d;
      al_hour_q  <= al_hour_d;
      al_min_q   <= al_min_d;
      sw_q       <= sw_d;
      paused_q   <= paused_d;
      buzzer_q   <= buzzer_d;
      tick_cnt_q <= tick_cnt_d;
      pending_q  <= pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ap_alarm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    al_hour_q < HOURS_PER_DAY && al_min_q < MINUTES_PER_HOUR)
    else $error("alarm hour or minute out of range");

  ap_sw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_q < SECONDS_PER_DAY)
    else $error("stopwatch count beyond one day");

  ap_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(sw_q) && $stable(mode_q) && $stable(pending_q))
    else $error("state moved without an accepted scan");

  ap_buzzer_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(buzzer_q) |-> mode_q == MODE_NORMAL)
    else $error("buzzer started outside normal mode");

  ap_sw_paused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && paused_q && !released[KEY_MINUTE] && !released[KEY_HOUR]
    |=> $stable(sw_q))
    else $error("paused stopwatch advanced");

endmodule

`default_nettype wire

// File: rtl/core/clock_alarm_stopwatch_controller_top.sv
// Top level of the clock, alarm and stopwatch controller.
// A scan is captured by the input register, its result then by the result register.
// Throughput: one scan per cycle, set by both registers, unless the output stalls.
// A stalled result holds both stages; stall reaches the input within the cycle.
// Reset clears control state: normal mode, alarm off, stopwatch 0 and paused,
// buzzer off, prescaler 0, ticks_per_second 100. Depends on cas_pkg.
`default_nettype none

module clock_alarm_stopwatch_controller_top import cas_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TPS_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire cas_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output cas_out_t              out_data_o
);

  logic    scan_valid;
  logic    scan_stall;
  cas_in_t scan_data;

  cas_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (scan_valid),
    .out_stall_i (scan_stall),
    .out_data_o  (scan_data)
  );

  cas_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (scan_valid),
    .in_stall_o  (scan_stall),
    .in_data_i   (scan_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
